@@ hw/rtl/gdc_pkg.sv @@
// ----------------------------------------------------------------------------
// gdc_pkg: shared types and constants of the Gregorian date calculator
// Payload structs, pipeline control struct, calendar tables, reciprocals.
// ----------------------------------------------------------------------------
`default_nettype none

package gdc_pkg;

    localparam int MaxYearDefault = 9999;

    localparam int DayW  = 5;
    localparam int MonW  = 4;
    localparam int YearW = 14;
    localparam int DoyW  = 9;
    localparam int WdayW = 3;

    // register stages from request to result
    localparam int NumStages = 4;

    // floor(x / 100) = (x * Div100Mul) >> Div100Shift, exact for x < 43690
    localparam int Div100Mul   = 20972;
    localparam int Div100Shift = 21;
    localparam int Div100MulW  = 15;
    localparam int QuoW        = 8;

    // floor(x / 7) = (x * Div7Mul) >> Div7Shift, exact for x < 43690
    localparam int Div7Mul   = 37450;
    localparam int Div7Shift = 18;
    localparam int Div7MulW  = 16;

    // weekday accumulator width, holds up to about 20600
    localparam int WsumW = 15;

    localparam logic [MonW-1:0] MonthJan = 4'd1;
    localparam logic [MonW-1:0] MonthFeb = 4'd2;
    localparam logic [MonW-1:0] MonthDec = 4'd12;

    localparam logic [DayW-1:0] DaysFebCommon = 5'd28;
    localparam logic [DayW-1:0] DaysFebLeap   = 5'd29;
    localparam logic [DayW-1:0] DaysLong      = 5'd31;

    typedef struct packed {
        logic [DayW-1:0]  day_in;
        logic [MonW-1:0]  month_in;
        logic [YearW-1:0] year_in;
    } gdc_in_t;

    typedef struct packed {
        logic             date_valid;
        logic [DayW-1:0]  next_day;
        logic [MonW-1:0]  next_month;
        logic [YearW-1:0] next_year;
        logic [DayW-1:0]  prev_day;
        logic [MonW-1:0]  prev_month;
        logic [YearW-1:0] prev_year;
        logic [DoyW-1:0]  day_of_year;
        logic [WdayW-1:0] weekday;
    } gdc_out_t;

    typedef struct packed {
        logic [NumStages-1:0] load;
        logic                 in_ready;
        logic                 out_valid;
    } gdc_pipe_ctrl_t;

    // month length outside February; February gives the common-year length
    function automatic logic [DayW-1:0] month_len_base(input logic [MonW-1:0] m);
        logic [DayW-1:0] len;
        case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DaysLong;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = DaysFebCommon;
            default:                                    len = '0;
        endcase
        return len;
    endfunction

    // days before the first of month m in a common year
    function automatic logic [DoyW-1:0] days_before(input logic [MonW-1:0] m);
        logic [DoyW-1:0] n;
        case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

    // (153 * mm + 2) / 5 mod 7, mm being the March-based month index
    function automatic logic [WdayW-1:0] month_term_mod7(input logic [MonW-1:0] m);
        logic [WdayW-1:0] t;
        case (m)
            4'd1:    t = 3'd5;
            4'd2:    t = 3'd1;
            4'd3:    t = 3'd0;
            4'd4:    t = 3'd3;
            4'd5:    t = 3'd5;
            4'd6:    t = 3'd1;
            4'd7:    t = 3'd3;
            4'd8:    t = 3'd6;
            4'd9:    t = 3'd2;
            4'd10:   t = 3'd4;
            4'd11:   t = 3'd0;
            4'd12:   t = 3'd2;
            default: t = 3'd0;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/gdc_stream_if.sv @@
// ----------------------------------------------------------------------------
// gdc_stream_if: valid/ready channel
// Carries one request per cycle at most; accepted when valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface gdc_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/gdc_pipe_ctrl.sv @@
// ----------------------------------------------------------------------------
// gdc_pipe_ctrl: valid bits and load enables of the date pipeline
// A stage loads when it is empty or the stage after it moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module gdc_pipe_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               out_ready,
    output gdc_pkg::gdc_pipe_ctrl_t ctrl
);

    localparam int Last = gdc_pkg::NumStages - 1;

    logic [gdc_pkg::NumStages-1:0] valid_reg;
    logic [gdc_pkg::NumStages-1:0] valid_next;
    logic [gdc_pkg::NumStages-1:0] load;

    always_comb
    begin
        load[Last] = !valid_reg[Last] || out_ready;
        for (int i = Last - 1; i >= 0; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end

    always_comb
    begin
        valid_next[0] = load[0] ? in_valid : valid_reg[0];
        for (int i = 1; i <= Last; i++)
        begin
            valid_next[i] = load[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctrl.load      = load;
    assign ctrl.in_ready  = load[0];
    assign ctrl.out_valid = valid_reg[Last];

endmodule

`default_nettype wire

@@ hw/rtl/gregorian_date_calculator_top.sv @@
// ----------------------------------------------------------------------------
// gregorian_date_calculator_top: Gregorian date validity, neighbors, weekday
// Each accepted request passes stage registers s1 to s4 in order to the output.
// Throughput: one request per cycle while not stalled; four register stages,
// the longest path being one constant reciprocal multiply of a 15-bit value.
// Backpressure stalls the stages in place; bubbles are filled while stalled.
// Reset clears only the stage valid bits; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_date_calculator_top #(
    parameter int MAX_YEAR = gdc_pkg::MaxYearDefault
) (
    input wire logic     clk,
    input wire logic     rst_n,
    gdc_stream_if.sink   date,
    gdc_stream_if.source result
);

    localparam int DayW  = gdc_pkg::DayW;
    localparam int MonW  = gdc_pkg::MonW;
    localparam int YearW = gdc_pkg::YearW;
    localparam int DoyW  = gdc_pkg::DoyW;
    localparam int WdayW = gdc_pkg::WdayW;
    localparam int QuoW  = gdc_pkg::QuoW;
    localparam int WsumW = gdc_pkg::WsumW;

    localparam int P100W = YearW + gdc_pkg::Div100MulW;
    localparam int P7W   = WsumW + gdc_pkg::Div7MulW;

    localparam logic [YearW-1:0] MaxYearW = YearW'(MAX_YEAR);

    typedef struct packed {
        logic [DayW-1:0]  d;
        logic [MonW-1:0]  m;
        logic [YearW-1:0] y;
        logic [YearW-1:0] z;          // year shifted so the year starts in March
        logic [QuoW-1:0]  q_y;        // y / 100
        logic [QuoW-1:0]  q_z;        // z / 100
        logic [DoyW-1:0]  days_prior;
        logic [WdayW-1:0] mterm;
        logic [DayW-1:0]  len;
        logic [DayW-1:0]  prev_len;
        logic             month_ok;
        logic             year_ok;
    } gdc_s2_t;

    typedef struct packed {
        logic             ok;
        logic [DayW-1:0]  nd;
        logic [MonW-1:0]  nm;
        logic [YearW-1:0] ny;
        logic [DayW-1:0]  pd;
        logic [MonW-1:0]  pm;
        logic [YearW-1:0] py;
        logic [DoyW-1:0]  doy;
        logic [WsumW-1:0] wsum;
    } gdc_s3_t;

    gdc_pkg::gdc_pipe_ctrl_t ctrl;

    gdc_pkg::gdc_in_t  s1_reg;
    gdc_s2_t           s2_reg;
    gdc_s2_t           s2_next;
    gdc_s3_t           s3_reg;
    gdc_s3_t           s3_next;
    gdc_pkg::gdc_out_t s4_reg;
    gdc_pkg::gdc_out_t s4_next;

    gdc_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (date.valid),
        .out_ready (result.ready),
        .ctrl      (ctrl)
    );

    assign date.ready     = ctrl.in_ready;
    assign result.valid   = ctrl.out_valid;
    assign result.payload = s4_reg;

    // stage 1: capture the request
    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            s1_reg <= date.payload;
        end
    end

    // stage 2: table lookups and the two divides by 100
    logic [YearW-1:0] z1;
    logic [P100W-1:0] prod_y;
    logic [P100W-1:0] prod_z;

    always_comb
    begin
        z1 = s1_reg.year_in - YearW'(s1_reg.month_in <= gdc_pkg::MonthFeb);
        prod_y = P100W'(s1_reg.year_in) * P100W'(gdc_pkg::Div100Mul);
        prod_z = P100W'(z1) * P100W'(gdc_pkg::Div100Mul);

        s2_next.d          = s1_reg.day_in;
        s2_next.m          = s1_reg.month_in;
        s2_next.y          = s1_reg.year_in;
        s2_next.z          = z1;
        s2_next.q_y        = prod_y[gdc_pkg::Div100Shift +: QuoW];
        s2_next.q_z        = prod_z[gdc_pkg::Div100Shift +: QuoW];
        s2_next.days_prior = gdc_pkg::days_before(s1_reg.month_in);
        s2_next.mterm      = gdc_pkg::month_term_mod7(s1_reg.month_in);
        s2_next.len        = gdc_pkg::month_len_base(s1_reg.month_in);
        s2_next.prev_len   = gdc_pkg::month_len_base(s1_reg.month_in - MonW'(1));
        s2_next.month_ok   = (s1_reg.month_in >= gdc_pkg::MonthJan) &&
                             (s1_reg.month_in <= gdc_pkg::MonthDec);
        s2_next.year_ok    = (s1_reg.year_in != '0) && (s1_reg.year_in <= MaxYearW);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[1])
        begin
            s2_reg <= s2_next;
        end
    end

    // stage 3: leap year, validity, neighbor dates, ordinal day, weekday sum
    logic             leap;
    logic             by100;
    logic [DayW-1:0]  feb_len;
    logic [DayW-1:0]  mlen;
    logic [QuoW-1:0]  q_z400;

    always_comb
    begin
        by100   = ({2'b00, s2_reg.y} == (QuoW'(s2_reg.q_y) * (YearW + 2)'(100)));
        leap    = (s2_reg.y[1:0] == 2'b00) && (!by100 || (s2_reg.q_y[1:0] == 2'b00));
        feb_len = leap ? gdc_pkg::DaysFebLeap : gdc_pkg::DaysFebCommon;
        mlen    = (s2_reg.m == gdc_pkg::MonthFeb) ? feb_len : s2_reg.len;
        q_z400  = s2_reg.q_z >> 2;

        s3_next.ok = s2_reg.year_ok && s2_reg.month_ok &&
                     (s2_reg.d != '0) && (s2_reg.d <= mlen);

        s3_next.nd = s2_reg.d + DayW'(1);
        s3_next.nm = s2_reg.m;
        s3_next.ny = s2_reg.y;
        if (s2_reg.d == mlen)
        begin
            s3_next.nd = DayW'(1);
            if (s2_reg.m == gdc_pkg::MonthDec)
            begin
                s3_next.nm = gdc_pkg::MonthJan;
                s3_next.ny = s2_reg.y + YearW'(1);
            end
            else
            begin
                s3_next.nm = s2_reg.m + MonW'(1);
            end
        end

        s3_next.pd = s2_reg.d - DayW'(1);
        s3_next.pm = s2_reg.m;
        s3_next.py = s2_reg.y;
        if (s2_reg.d == DayW'(1))
        begin
            if (s2_reg.m == gdc_pkg::MonthJan)
            begin
                s3_next.pm = gdc_pkg::MonthDec;
                s3_next.py = s2_reg.y - YearW'(1);
                s3_next.pd = gdc_pkg::DaysLong;
            end
            else
            begin
                s3_next.pm = s2_reg.m - MonW'(1);
                s3_next.pd = (s2_reg.m == gdc_pkg::MonthFeb + MonW'(1)) ? feb_len
                                                                        : s2_reg.prev_len;
            end
        end

        s3_next.doy = s2_reg.days_prior + DoyW'(s2_reg.d) +
                      DoyW'(leap && (s2_reg.m > gdc_pkg::MonthFeb));

        // Julian day number reduced mod 7: 365 == 1 and the offsets sum to 1
        s3_next.wsum = WsumW'(s2_reg.d) + WsumW'(s2_reg.mterm) + WsumW'(s2_reg.z) +
                       WsumW'(s2_reg.z >> 2) + WsumW'(q_z400) - WsumW'(s2_reg.q_z) +
                       WsumW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[2])
        begin
            s3_reg <= s3_next;
        end
    end

    // stage 4: weekday remainder and zeroing of invalid dates
    logic [P7W-1:0]   prod_7;
    logic [WsumW-1:0] q7;
    logic [WsumW-1:0] rem7;

    always_comb
    begin
        prod_7 = P7W'(s3_reg.wsum) * P7W'(gdc_pkg::Div7Mul);
        q7     = WsumW'(prod_7 >> gdc_pkg::Div7Shift);
        rem7   = s3_reg.wsum - WsumW'(q7 * WsumW'(7));

        s4_next = '0;
        if (s3_reg.ok)
        begin
            s4_next.date_valid  = 1'b1;
            s4_next.next_day    = s3_reg.nd;
            s4_next.next_month  = s3_reg.nm;
            s4_next.next_year   = s3_reg.ny;
            s4_next.prev_day    = s3_reg.pd;
            s4_next.prev_month  = s3_reg.pm;
            s4_next.prev_year   = s3_reg.py;
            s4_next.day_of_year = s3_reg.doy;
            s4_next.weekday     = rem7[WdayW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[3])
        begin
            s4_reg <= s4_next;
        end
    end

    // an invalid date carries nothing but a cleared flag
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.payload.date_valid |-> (result.payload == '0))
        else $error("invalid date result has nonzero fields");

    // weekday remainder and ordinal day in range for a real date
    a_valid_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.payload.date_valid |->
            (result.payload.weekday <= 3'd6) && (result.payload.day_of_year != '0) &&
            (result.payload.day_of_year <= 9'd366))
        else $error("weekday or day of year out of range");

    // neighbor dates of a real date are never the empty day
    a_neighbors: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.payload.date_valid |->
            (result.payload.next_day != '0) && (result.payload.prev_day != '0) &&
            (result.payload.next_month != '0) && (result.payload.prev_month != '0))
        else $error("neighbor date has zero day or month");

endmodule

`default_nettype wire
